// ===== hdl/flow_vector_to_hsv_defines.svh =====
// Assertion macros for the flow-to-HSV block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FLOW_VECTOR_TO_HSV_DEFINES_SVH
`define FLOW_VECTOR_TO_HSV_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property while out of reset.
`define FVH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fvh assertion failed");
// Check a property at every edge, reset included.
`define FVH_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fvh assertion failed");
`else
`define FVH_ASSERT(lbl, prop)
`define FVH_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== hdl/fvh_pkg.sv =====
// Shared types, constants and tables of the flow-to-HSV block.
// No dependencies.
package fvh_pkg;

  localparam int THR_W      = 16;
  localparam int GAIN_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_GAIN      = 2'd1;

  localparam logic [THR_W-1:0]  BOOST_THRESHOLD_RST = 16'd128;
  localparam logic [GAIN_W-1:0] BOOST_GAIN_RST      = 4'd8;

  // tangent table, scaled by 10^9
  localparam int TAN_W = 30;
  localparam logic [TAN_W-1:0] TAN_SCALE = 30'd1000000000;

  localparam int HUE_SECTORS      = 22;
  localparam int SECTOR_W         = 5;
  localparam int HUE_SEARCH_STEPS = 5;

  localparam int ROOT_BITS = 8;
  localparam int RAD_W     = 2 * ROOT_BITS;
  localparam int REM_W     = RAD_W - ROOT_BITS + 3;

  localparam int HUE_W    = 8;
  localparam int BRIGHT_W = 8;

  localparam logic [HUE_W-1:0]    QUAD_SECTORS = 8'd45;
  localparam logic [HUE_W-1:0]    HUE_MAX      = 8'd179;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 8'd255;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } fvh_quad_t;

  typedef struct packed {
    logic                valid;
    fvh_quad_t           quad;
    logic                swapped;
    logic                zero;
    logic                sat;
    logic                eq;
    logic [SECTOR_W-1:0] sector;
  } fvh_ctl_t;

  function automatic logic [TAN_W-1:0] fvh_tan(input logic [SECTOR_W-1:0] k);
    logic [TAN_W-1:0] t;
    case (k)
      5'd1:    t = 30'd34920769;
      5'd2:    t = 30'd69926812;
      5'd3:    t = 30'd105104235;
      5'd4:    t = 30'd140540835;
      5'd5:    t = 30'd176326981;
      5'd6:    t = 30'd212556562;
      5'd7:    t = 30'd249328003;
      5'd8:    t = 30'd286745386;
      5'd9:    t = 30'd324919696;
      5'd10:   t = 30'd363970234;
      5'd11:   t = 30'd404026226;
      5'd12:   t = 30'd445228685;
      5'd13:   t = 30'd487732589;
      5'd14:   t = 30'd531709432;
      5'd15:   t = 30'd577350269;
      5'd16:   t = 30'd624869352;
      5'd17:   t = 30'd674508517;
      5'd18:   t = 30'd726542528;
      5'd19:   t = 30'd781285627;
      5'd20:   t = 30'd839099631;
      5'd21:   t = 30'd900404044;
      5'd22:   t = 30'd965688775;
      default: t = '0;
    endcase
    return t;
  endfunction

  // hue offset of a quadrant, in 2-degree units
  function automatic logic [HUE_W-1:0] quad_base(input fvh_quad_t q);
    logic [HUE_W-1:0] b;
    case (q)
      QUAD_0:  b = 8'd0;
      QUAD_1:  b = 8'd45;
      QUAD_2:  b = 8'd90;
      QUAD_3:  b = 8'd135;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/fvh_in_if.sv =====
// Input channel of the flow-to-HSV block: one flow vector per beat.
// Standalone; no package needed.
interface fvh_in_if #(
  parameter int FLOW_BITS = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [FLOW_BITS-1:0] flow_x;
  logic signed [FLOW_BITS-1:0] flow_y;

  modport source (output valid, output flow_x, output flow_y, input ready);
  modport sink   (input valid, input flow_x, input flow_y, output ready);
endinterface

// ===== hdl/fvh_out_if.sv =====
// Result channel of the flow-to-HSV block: hue and brightness per beat.
// Uses fvh_pkg for field widths.
interface fvh_out_if ();
  logic                             valid;
  logic                             ready;
  logic [fvh_pkg::HUE_W-1:0]    hue;
  logic [fvh_pkg::BRIGHT_W-1:0] brightness;

  modport source (output valid, output hue, output brightness, input ready);
  modport sink   (input valid, input hue, input brightness, output ready);
endinterface

// ===== hdl/fvh_cfg_if.sv =====
// Register write channel of the flow-to-HSV block.
// Uses fvh_pkg for index and data widths.
interface fvh_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [fvh_pkg::CFG_IDX_W-1:0]  index;
  logic [fvh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fvh_front.sv =====
// Front pipeline: quadrant fold, squared length, boost and saturation.
// Feeds the digit cells; uses fvh_pkg.
module fvh_front #(
  parameter int FLOW_BITS     = 16,
  parameter int FRACTION_BITS = 6
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic signed [FLOW_BITS-1:0]                   flow_x,
  input  logic signed [FLOW_BITS-1:0]                   flow_y,
  input  logic [fvh_pkg::THR_W-1:0]                     thr,
  input  logic [fvh_pkg::GAIN_W-1:0]                    gain,
  output fvh_pkg::fvh_ctl_t                             ctl_o,
  output logic [FLOW_BITS-1:0]                          den_o,
  output logic [FLOW_BITS+fvh_pkg::TAN_W-1:0]           num_o,
  output logic [fvh_pkg::RAD_W-1:0]                     m_o
);

  localparam int SW  = 2 * FLOW_BITS;
  localparam int CW  = (SW > 2 * fvh_pkg::THR_W) ? SW : 2 * fvh_pkg::THR_W;
  localparam int VW  = SW + 2 * fvh_pkg::GAIN_W;
  localparam int LW  = (VW > 2 * FRACTION_BITS + fvh_pkg::RAD_W + 1) ?
                       VW : 2 * FRACTION_BITS + fvh_pkg::RAD_W + 1;
  localparam int PW  = FLOW_BITS + fvh_pkg::TAN_W;
  localparam int GGW = 2 * fvh_pkg::GAIN_W;
  localparam int TSW = 2 * fvh_pkg::THR_W;

  // stage 0: fold into first quadrant
  logic [FLOW_BITS-1:0] x_u, y_u, ax, ay, u, v;
  logic                 xpos, xneg, ypos, yneg, swap;
  fvh_pkg::fvh_quad_t   quad;
  fvh_pkg::fvh_ctl_t    ctl0_nxt;

  always_comb begin
    x_u  = flow_x;
    y_u  = flow_y;
    ax   = flow_x[FLOW_BITS-1] ? (~x_u + 1'b1) : x_u;
    ay   = flow_y[FLOW_BITS-1] ? (~y_u + 1'b1) : y_u;
    xneg = flow_x[FLOW_BITS-1];
    yneg = flow_y[FLOW_BITS-1];
    xpos = !xneg && (x_u != '0);
    ypos = !yneg && (y_u != '0);
    if (xpos && !yneg) begin
      quad = fvh_pkg::QUAD_0;
    end else if (!xpos && ypos) begin
      quad = fvh_pkg::QUAD_1;
    end else if (xneg && !ypos) begin
      quad = fvh_pkg::QUAD_2;
    end else begin
      quad = fvh_pkg::QUAD_3;
    end
    if (quad == fvh_pkg::QUAD_1 || quad == fvh_pkg::QUAD_3) begin
      u = ay;
      v = ax;
    end else begin
      u = ax;
      v = ay;
    end
    swap = v > u;
    ctl0_nxt         = '0;
    ctl0_nxt.valid   = in_valid;
    ctl0_nxt.quad    = quad;
    ctl0_nxt.swapped = swap;
    ctl0_nxt.zero    = (x_u == '0) && (y_u == '0);
  end

  fvh_pkg::fvh_ctl_t    ctl0_r, ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  logic [FLOW_BITS-1:0] ax0_r, ay0_r, den0_r, num0_r;
  logic [FLOW_BITS-1:0] den1_r, den2_r, den3_r, den4_r;
  logic [SW-1:0]        sqx1_r, sqy1_r, s2_r;
  logic [PW-1:0]        numsc1_r, numsc2_r, numsc3_r, numsc4_r;
  logic [TSW-1:0]       thrsq1_r;
  logic                 boost2_r;
  logic [GGW-1:0]       gg2_r;
  logic [VW-1:0]        val3_r;
  logic [fvh_pkg::RAD_W-1:0] m4_r;

  logic [SW-1:0]     s_sum;
  logic [LW-1:0]     v_sh;
  logic              sat;
  fvh_pkg::fvh_ctl_t ctl4_nxt;

  always_comb begin
    s_sum        = sqx1_r + sqy1_r;
    v_sh         = LW'(val3_r) >> (2 * FRACTION_BITS);
    sat          = |v_sh[LW-1:fvh_pkg::RAD_W];
    ctl4_nxt     = ctl3_r;
    ctl4_nxt.sat = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else if (en) begin
      ctl0_r <= ctl0_nxt;
      ctl1_r <= ctl0_r;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0_r    <= ax;
      ay0_r    <= ay;
      den0_r   <= swap ? v : u;
      num0_r   <= swap ? u : v;
      sqx1_r   <= SW'(ax0_r) * SW'(ax0_r);
      sqy1_r   <= SW'(ay0_r) * SW'(ay0_r);
      numsc1_r <= PW'(num0_r) * PW'(fvh_pkg::TAN_SCALE);
      thrsq1_r <= TSW'(thr) * TSW'(thr);
      den1_r   <= den0_r;
      s2_r     <= s_sum;
      boost2_r <= CW'(s_sum) > CW'(thrsq1_r);
      gg2_r    <= GGW'(gain) * GGW'(gain);
      den2_r   <= den1_r;
      numsc2_r <= numsc1_r;
      val3_r   <= boost2_r ? (VW'(s2_r) * VW'(gg2_r)) : VW'(s2_r);
      den3_r   <= den2_r;
      numsc3_r <= numsc2_r;
      m4_r     <= v_sh[fvh_pkg::RAD_W-1:0];
      den4_r   <= den3_r;
      numsc4_r <= numsc3_r;
    end
  end

  assign ctl_o = ctl4_r;
  assign den_o = den4_r;
  assign num_o = numsc4_r;
  assign m_o   = m4_r;

endmodule

// ===== hdl/fvh_cell.sv =====
// One digit cell: a root bit of the brightness and, in the first cells,
// one halving step of the hue sector search. Two register stages; uses fvh_pkg.
module fvh_cell #(
  parameter int FLOW_BITS = 16,
  parameter int STEP      = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  fvh_pkg::fvh_ctl_t                   ctl_i,
  input  logic [FLOW_BITS-1:0]                den_i,
  input  logic [FLOW_BITS+fvh_pkg::TAN_W-1:0] num_i,
  input  logic [fvh_pkg::RAD_W-1:0]           m_i,
  input  logic [fvh_pkg::REM_W-1:0]           rem_i,
  input  logic [fvh_pkg::ROOT_BITS-1:0]       root_i,
  output fvh_pkg::fvh_ctl_t                   ctl_o,
  output logic [FLOW_BITS-1:0]                den_o,
  output logic [FLOW_BITS+fvh_pkg::TAN_W-1:0] num_o,
  output logic [fvh_pkg::RAD_W-1:0]           m_o,
  output logic [fvh_pkg::REM_W-1:0]           rem_o,
  output logic [fvh_pkg::ROOT_BITS-1:0]       root_o
);

  localparam int PW    = FLOW_BITS + fvh_pkg::TAN_W;
  localparam int TW    = fvh_pkg::SECTOR_W + 1;
  localparam int HUE_B = (1 << (fvh_pkg::HUE_SEARCH_STEPS - 1)) >> STEP;
  localparam int PAIR  = fvh_pkg::ROOT_BITS - 1 - STEP;
  localparam int RB    = fvh_pkg::ROOT_BITS;
  localparam int RW    = fvh_pkg::REM_W;

  // stage A: form the trial sector and its tangent product
  logic [TW-1:0] t;
  logic          try_s;

  always_comb begin
    t     = TW'(ctl_i.sector) + TW'(HUE_B);
    try_s = (HUE_B != 0) && (t <= TW'(fvh_pkg::HUE_SECTORS));
  end

  fvh_pkg::fvh_ctl_t      ctl_a_r, ctl_b_r;
  logic [FLOW_BITS-1:0]   den_a_r, den_b_r;
  logic [PW-1:0]          num_a_r, num_b_r, prod_a_r;
  logic [fvh_pkg::RAD_W-1:0] m_a_r, m_b_r;
  logic [RW-1:0]          rem_a_r, rem_b_r;
  logic [RB-1:0]          root_a_r, root_b_r;
  logic [TW-1:0]          t_a_r;
  logic                   try_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_a_r  <= den_i;
      num_a_r  <= num_i;
      m_a_r    <= m_i;
      rem_a_r  <= rem_i;
      root_a_r <= root_i;
      t_a_r    <= t;
      try_a_r  <= try_s;
      prod_a_r <= PW'(den_i) * PW'(fvh_pkg::fvh_tan(t[fvh_pkg::SECTOR_W-1:0]));
    end
  end

  // stage B: sector compare and one restoring root step
  fvh_pkg::fvh_ctl_t ctl_b_nxt;
  logic [RW-1:0]     rem_sh, trial, rem_b_nxt;
  logic [RB-1:0]     root_b_nxt;

  always_comb begin
    ctl_b_nxt = ctl_a_r;
    if (try_a_r && (num_a_r >= prod_a_r)) begin
      ctl_b_nxt.sector = t_a_r[fvh_pkg::SECTOR_W-1:0];
      ctl_b_nxt.eq     = (num_a_r == prod_a_r);
    end
    rem_sh = {rem_a_r[RW-3:0], m_a_r[2*PAIR +: 2]};
    trial  = RW'({root_a_r, 2'b01});
    if (rem_sh >= trial) begin
      rem_b_nxt  = rem_sh - trial;
      root_b_nxt = {root_a_r[RB-2:0], 1'b1};
    end else begin
      rem_b_nxt  = rem_sh;
      root_b_nxt = {root_a_r[RB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_b_r <= ctl_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_b_r  <= den_a_r;
      num_b_r  <= num_a_r;
      m_b_r    <= m_a_r;
      rem_b_r  <= rem_b_nxt;
      root_b_r <= root_b_nxt;
    end
  end

  assign ctl_o  = ctl_b_r;
  assign den_o  = den_b_r;
  assign num_o  = num_b_r;
  assign m_o    = m_b_r;
  assign rem_o  = rem_b_r;
  assign root_o = root_b_r;

endmodule

// ===== hdl/fvh_outbuf.sv =====
// Result assembly and output register with a one-beat skid stage.
// Drives the pipeline advance enable; uses fvh_pkg and fvh_out_if.
`include "flow_vector_to_hsv_defines.svh"

module fvh_outbuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fvh_pkg::fvh_ctl_t             ctl_i,
  input  logic [fvh_pkg::ROOT_BITS-1:0] root_i,
  output logic                          en,
  fvh_out_if.source                     out_ch
);

  logic [fvh_pkg::HUE_W-1:0]    base, sect, off, res_hue;
  logic [fvh_pkg::BRIGHT_W-1:0] res_bright;
  logic                         res_valid;

  always_comb begin
    base = fvh_pkg::quad_base(ctl_i.quad);
    sect = fvh_pkg::HUE_W'(ctl_i.sector);
    if (!ctl_i.swapped) begin
      off = sect;
    end else if (ctl_i.eq) begin
      off = fvh_pkg::QUAD_SECTORS - sect;
    end else begin
      off = fvh_pkg::QUAD_SECTORS - 8'd1 - sect;
    end
    res_hue    = ctl_i.zero ? '0 : base + off;
    res_bright = ctl_i.sat ? fvh_pkg::BRIGHT_MAX : fvh_pkg::BRIGHT_W'(root_i);
    res_valid  = ctl_i.valid;
  end

  logic                         out_valid_r, out_valid_nxt;
  logic                         skid_valid_r, skid_valid_nxt;
  logic [fvh_pkg::HUE_W-1:0]    out_hue_r, skid_hue_r;
  logic [fvh_pkg::BRIGHT_W-1:0] out_bright_r, skid_bright_r;
  logic                         load_out, load_skid, from_skid;

  // pipeline moves only while the skid stage is empty
  assign en = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    from_skid      = 1'b0;
    if (skid_valid_r) begin
      if (out_ch.ready) begin
        from_skid      = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_nxt = 1'b0;
      end
      if (res_valid) begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
        end else begin
          // park the beat, freeze the pipe next cycle
          load_skid      = 1'b1;
          skid_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hue_r    <= res_hue;
      out_bright_r <= res_bright;
    end else if (from_skid) begin
      out_hue_r    <= skid_hue_r;
      out_bright_r <= skid_bright_r;
    end
    if (load_skid) begin
      skid_hue_r    <= res_hue;
      skid_bright_r <= res_bright;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hue        = out_hue_r;
  assign out_ch.brightness = out_bright_r;

  `FVH_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r)
  `FVH_ASSERT(a_frozen_holds_result, !en && res_valid |=> res_valid)
  `FVH_ASSERT(a_hue_in_range, out_valid_r |-> out_hue_r <= fvh_pkg::HUE_MAX)

endmodule

// ===== hdl/flow_vector_to_hsv.sv =====
// Top level: optical-flow vector to hue and brightness, one pixel per beat.
// Uses fvh_pkg, the three channel interfaces, fvh_front, fvh_cell, fvh_outbuf.
//
//  port      dir   beat payload                  notes
//  in_flow   sink  flow_x, flow_y (signed)       one flow vector
//  out_hsv   src   hue 0..179, brightness 0..255 one result per vector
//  cfg_wr    sink  index, data                   0 threshold, 1 gain; ready tied high
//
// Throughput is one vector per clock while out_hsv is not stalled; the path holds five front
// stages, eight digit cells of two stages each (one root bit apiece), one output register.
// rst_n is synchronous: clears all valid flags, threshold to 128, gain to 8.
// On an output stall the beat parks in a skid register and the whole pipe
// freezes the next cycle; in_flow.ready is the inverse of that registered freeze flag.
`include "flow_vector_to_hsv_defines.svh"

module flow_vector_to_hsv #(
  parameter int FLOW_BITS     = 16,
  parameter int FRACTION_BITS = 6
) (
  input logic       clk,
  input logic       rst_n,
  fvh_in_if.sink    in_flow,
  fvh_out_if.source out_hsv,
  fvh_cfg_if.sink   cfg_wr
);

  localparam int PW = FLOW_BITS + fvh_pkg::TAN_W;
  localparam int NC = fvh_pkg::ROOT_BITS;

  logic [fvh_pkg::THR_W-1:0]  thr_r;
  logic [fvh_pkg::GAIN_W-1:0] gain_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= fvh_pkg::BOOST_THRESHOLD_RST;
      gain_r <= fvh_pkg::BOOST_GAIN_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.index)
        fvh_pkg::CFG_BOOST_THRESHOLD: thr_r  <= cfg_wr.data[fvh_pkg::THR_W-1:0];
        fvh_pkg::CFG_BOOST_GAIN:      gain_r <= cfg_wr.data[fvh_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;

  assign in_flow.ready = en;

  fvh_pkg::fvh_ctl_t               ctl_c  [0:NC];
  logic [FLOW_BITS-1:0]            den_c  [0:NC];
  logic [PW-1:0]                   num_c  [0:NC];
  logic [fvh_pkg::RAD_W-1:0]       m_c    [0:NC];
  logic [fvh_pkg::REM_W-1:0]       rem_c  [0:NC];
  logic [fvh_pkg::ROOT_BITS-1:0]   root_c [0:NC];

  fvh_front #(
    .FLOW_BITS     (FLOW_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_flow.valid),
    .flow_x   (in_flow.flow_x),
    .flow_y   (in_flow.flow_y),
    .thr      (thr_r),
    .gain     (gain_r),
    .ctl_o    (ctl_c[0]),
    .den_o    (den_c[0]),
    .num_o    (num_c[0]),
    .m_o      (m_c[0])
  );

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    fvh_cell #(
      .FLOW_BITS (FLOW_BITS),
      .STEP      (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_c[i]),
      .den_i  (den_c[i]),
      .num_i  (num_c[i]),
      .m_i    (m_c[i]),
      .rem_i  (rem_c[i]),
      .root_i (root_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .den_o  (den_c[i+1]),
      .num_o  (num_c[i+1]),
      .m_o    (m_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .root_o (root_c[i+1])
    );
  end

  fvh_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_c[NC]),
    .root_i (root_c[NC]),
    .en     (en),
    .out_ch (out_hsv)
  );

  `FVH_ASSERT_RST(a_cfg_reset_values, !rst_n |=> thr_r == fvh_pkg::BOOST_THRESHOLD_RST && gain_r == fvh_pkg::BOOST_GAIN_RST)
  `FVH_ASSERT(a_frozen_no_new_tail, !en |=> $stable(ctl_c[NC]))

endmodule

// ===== tb/flow_vector_to_hsv_tb.sv =====
// Self-checking bench for flow_vector_to_hsv: random and directed flow vectors,
// hue and brightness predicted per beat and compared in order.
// Needs fvh_pkg, the three channel interfaces and the flow_vector_to_hsv RTL.
`timescale 1ns / 100ps

module flow_vector_to_hsv_tb;

  localparam int FLOW_BITS  = 16;
  localparam int FRAC       = 6;
  localparam int PHASES     = 6;
  localparam int PER_PHASE  = 180;
  localparam int LONG_HOLD  = 300;
  localparam int QUIET_MAX  = 3000;
  localparam int TAIL_WAIT  = 30;
  localparam longint TAN_ONE = 64'd1000000000;

  // indexes with no register behind them; writes there must be dropped
  localparam logic [fvh_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [fvh_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [FLOW_BITS-1:0] x;
    logic signed [FLOW_BITS-1:0] y;
  } flow_vec_t;

  typedef struct packed {
    logic signed [FLOW_BITS-1:0]   x;
    logic signed [FLOW_BITS-1:0]   y;
    logic [fvh_pkg::HUE_W-1:0]    hue;
    logic [fvh_pkg::BRIGHT_W-1:0] brightness;
  } hsv_due_t;

  // tan(2k deg) scaled by 10^9
  longint tan_2deg [0:22] = '{
    0, 34920769, 69926812, 105104235, 140540835, 176326981,
    212556562, 249328003, 286745386, 324919696, 363970234,
    404026226, 445228685, 487732589, 531709432, 577350269,
    624869352, 674508517, 726542528, 781285627, 839099631,
    900404044, 965688775
  };

  int directed_xy [0:47] = '{
    0, 0,        32767, 0,     -32768, 0,     0, 32767,
    0, -32768,   32767, 32767, -32768, -32768, 32767, -32768,
    -32768, 32767, 1, 0,       0, 1,          -1, 0,
    0, -1,       1, 1,         -1, 1,         1, -1,
    128, 0,      129, 0,       0, -129,       90, 91,
    2040, 0,     2039, 0,      -5, 3,         7, -300
  };

  logic clk;
  logic rst_n;

  fvh_in_if #(.FLOW_BITS(FLOW_BITS)) in_if ();
  fvh_out_if out_if ();
  fvh_cfg_if cfg_if ();

  flow_vector_to_hsv #(
    .FLOW_BITS(FLOW_BITS),
    .FRACTION_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_flow(in_if),
    .out_hsv(out_if),
    .cfg_wr(cfg_if)
  );

  flow_vec_t pending_flow[$];
  hsv_due_t  hsv_due[$];

  logic [fvh_pkg::THR_W-1:0]  thr_shadow  = fvh_pkg::BOOST_THRESHOLD_RST;
  logic [fvh_pkg::GAIN_W-1:0] gain_shadow = fvh_pkg::BOOST_GAIN_RST;

  int idle_pct      = 0;
  int in_gap        = 0;
  int out_gap       = 0;
  int hold_left     = 0;
  int hold_requests = 0;
  int holds_granted = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // last k in 1..22 with num/den >= tan(2k deg); tie marks an exact hit on it
  function automatic int unsigned sectors_below(input longint den, input longint num,
                                                output bit tie);
    int unsigned k;
    int unsigned c;
    c   = 0;
    tie = 1'b0;
    for (k = 1; k <= 22; k++) begin
      if (num * TAN_ONE >= den * tan_2deg[k]) begin
        c   = k;
        tie = (num * TAN_ONE == den * tan_2deg[k]);
      end
    end
    return c;
  endfunction

  function automatic hsv_due_t hsv_of_flow(input logic signed [FLOW_BITS-1:0] fx,
                                           input logic signed [FLOW_BITS-1:0] fy,
                                           input logic [fvh_pkg::THR_W-1:0] thr,
                                           input logic [fvh_pkg::GAIN_W-1:0] gain);
    hsv_due_t    r;
    longint      x, y, u, v, sq, scaled, thr_l, gain_l, probe, full;
    int unsigned base, c, b;
    int          i;
    bit          tie;
    x      = longint'(fx);
    y      = longint'(fy);
    thr_l  = longint'(thr);
    gain_l = longint'(gain);
    r.x    = fx;
    r.y    = fy;
    if (x == 0 && y == 0) begin
      r.hue = '0;
    end else begin
      // rotate into the first quadrant
      if (x > 0 && y >= 0) begin
        base = 0;   u = x;  v = y;
      end else if (x <= 0 && y > 0) begin
        base = 45;  u = y;  v = -x;
      end else if (x < 0 && y <= 0) begin
        base = 90;  u = -x; v = -y;
      end else begin
        base = 135; u = -y; v = x;
      end
      if (v <= u) begin
        c     = sectors_below(u, v, tie);
        r.hue = fvh_pkg::HUE_W'(base + c);
      end else begin
        // above 45 degrees: mirror through the diagonal
        c     = sectors_below(v, u, tie);
        r.hue = fvh_pkg::HUE_W'(base + (tie ? 45 - c : 44 - c));
      end
    end
    sq     = x * x + y * y;
    scaled = (sq > thr_l * thr_l) ? sq * gain_l * gain_l : sq;
    full   = longint'(256) << FRAC;
    if (scaled >= full * full) begin
      r.brightness = 8'd255;
    end else begin
      b = 0;
      for (i = 7; i >= 0; i--) begin
        probe = longint'(b | (1 << i)) << FRAC;
        if (probe * probe <= scaled)
          b = b | (1 << i);
      end
      r.brightness = fvh_pkg::BRIGHT_W'(b);
    end
    return r;
  endfunction

  function automatic flow_vec_t rand_flow(input int thr);
    flow_vec_t v;
    int        pick, w, m, r;
    logic      swap_xy;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      v.x = FLOW_BITS'($urandom);
      v.y = FLOW_BITS'($urandom);
    end else if (pick < 65) begin
      w   = $urandom_range(1, 14);
      m   = 1 << w;
      v.x = FLOW_BITS'(int'($urandom_range(0, 2 * m)) - m);
      v.y = FLOW_BITS'(int'($urandom_range(0, 2 * m)) - m);
    end else if (pick < 82) begin
      // straddle the boost threshold
      r = thr + int'($urandom_range(0, 4)) - 2;
      if (r > 32767) r = 32767;
      if (r < 0) r = 0;
      v.x = FLOW_BITS'($urandom_range(0, 1) ? r : -r);
      v.y = FLOW_BITS'(int'($urandom_range(0, 2)) - 1);
      swap_xy = 1'($urandom_range(0, 1));
      if (swap_xy) v = '{x: v.y, y: v.x};
    end else begin
      // on or next to an axis or a diagonal
      m   = $urandom_range(1, 32767);
      v.x = FLOW_BITS'(m);
      case ($urandom_range(0, 2))
        0:       v.y = 0;
        1:       v.y = FLOW_BITS'(m);
        default: v.y = FLOW_BITS'(m + int'($urandom_range(0, 2)) - 1);
      endcase
      if ($urandom_range(0, 1)) v.x = -v.x;
      if ($urandom_range(0, 1)) v.y = -v.y;
      swap_xy = 1'($urandom_range(0, 1));
      if (swap_xy) v = '{x: v.y, y: v.x};
    end
    return v;
  endfunction

  task automatic write_reg(input logic [fvh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fvh_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_flow.size() != 0 || in_if.valid || hsv_due.size() != 0);
  endtask

  // input side: track register writes, predict accepted beats, offer the next
  always @(posedge clk) begin : drive_flow
    flow_vec_t nxt;
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      in_if.flow_x <= '0;
      in_if.flow_y <= '0;
      in_gap      = 0;
      thr_shadow  = fvh_pkg::BOOST_THRESHOLD_RST;
      gain_shadow = fvh_pkg::BOOST_GAIN_RST;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          fvh_pkg::CFG_BOOST_THRESHOLD: thr_shadow  = cfg_if.data[fvh_pkg::THR_W-1:0];
          fvh_pkg::CFG_BOOST_GAIN:      gain_shadow = cfg_if.data[fvh_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        hsv_due.push_back(hsv_of_flow(in_if.flow_x, in_if.flow_y, thr_shadow, gain_shadow));
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_if.valid <= 1'b0;
          in_gap--;
        end else if (pending_flow.size() > 0) begin
          nxt = pending_flow.pop_front();
          in_if.valid  <= 1'b1;
          in_if.flow_x <= nxt.x;
          in_if.flow_y <= nxt.y;
          if (int'($urandom_range(0, 99)) < idle_pct)
            in_gap = $urandom_range(1, 13);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side: check each beat against the oldest prediction, then pace ready
  always @(posedge clk) begin : take_hsv
    hsv_due_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (hsv_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: hue %0d brightness %0d", out_if.hue, out_if.brightness);
      end else begin
        want = hsv_due.pop_front();
        if (out_if.hue !== want.hue || out_if.brightness !== want.brightness) begin
          mismatches++;
          if (mismatches <= 10)
            $display("flow (%0d,%0d): hue exp %0d got %0d, brightness exp %0d got %0d",
                     want.x, want.y, want.hue, out_if.hue,
                     want.brightness, out_if.brightness);
        end
      end
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (holds_granted != hold_requests) begin
      // long stall: let the pipe fill and push back on the input
      holds_granted++;
      hold_left = LONG_HOLD - 1;
      out_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_if.ready <= 1'b0;
      out_gap--;
    end else begin
      out_if.ready <= 1'b1;
      if (int'($urandom_range(0, 99)) < idle_pct)
        out_gap = $urandom_range(1, 13);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("flow_vector_to_hsv_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase_idle [0:PHASES-1] = '{30, 0, 50, 15, 30, 0};
    logic [fvh_pkg::CFG_DATA_W-1:0] phase_thr  [0:PHASES-1] =
      '{16'd0, 16'hFFFF, 16'd200, 16'd1000, 16'd40, 16'd128};
    logic [fvh_pkg::CFG_DATA_W-1:0] phase_gain [0:PHASES-1] =
      '{16'h0001, 16'hFFFF, 16'hFFF0, 16'hA5A3, 16'h000F, 16'h0008};
    int p, i;
    flow_vec_t v;

    rst_n        = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = fvh_pkg::CFG_BOOST_THRESHOLD;
    cfg_if.data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corners, axes, diagonals and the threshold edge at reset settings
    @(negedge clk);
    idle_pct = 30;
    for (i = 0; i < 48; i += 2) begin
      v.x = FLOW_BITS'(directed_xy[i]);
      v.y = FLOW_BITS'(directed_xy[i + 1]);
      pending_flow.push_back(v);
    end
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      write_reg(p[0] ? CFG_SPARE_B : CFG_SPARE_A, fvh_pkg::CFG_DATA_W'($urandom));
      write_reg(fvh_pkg::CFG_BOOST_THRESHOLD, phase_thr[p]);
      write_reg(fvh_pkg::CFG_BOOST_GAIN, phase_gain[p]);
      @(negedge clk);
      idle_pct = phase_idle[p];
      for (i = 0; i < PER_PHASE; i++)
        pending_flow.push_back(rand_flow(int'(phase_thr[p])));
      if (p == 1) begin
        @(negedge clk);
        hold_requests++;
      end
      wait_drained();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && hsv_due.size() == 0)
      $display("flow_vector_to_hsv_tb: done, clean");
    else
      $display("flow_vector_to_hsv_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fvh_pkg.sv
hdl/fvh_in_if.sv
hdl/fvh_out_if.sv
hdl/fvh_cfg_if.sv
hdl/fvh_front.sv
hdl/fvh_cell.sv
hdl/fvh_outbuf.sv
hdl/flow_vector_to_hsv.sv
tb/flow_vector_to_hsv_tb.sv
